@@ src/bdq_pkg.sv @@
// Shared types and constants of the bounded deque with search.
`default_nettype none
package bdq_pkg;

   localparam int ELEM_W  = 32;
   localparam int CMD_W   = 3;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;
   localparam int REQ_DATA_W  = 32;
   localparam int REQ_USER_W  = 8;
   localparam int RSP_DATA_W  = 40;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_SEARCH     = 3'd4,
      CMD_LENGTH     = 3'd5,
      CMD_LIST       = 3'd6,
      CMD_CLEAR      = 3'd7
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // latch the incoming word, clear scan state
      logic exec;       // apply a single-result command and emit its result
      logic rd_en;      // read the store entry at the scan index
      logic use_search; // fold the read entry into the search flag
      logic emit_elem;  // emit the read entry as a list result
      logic idx_inc;    // advance the scan index
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_start; // incoming command walks the store
      logic is_list;    // latched command is a listing
      logic idx_last;   // scan index is at the back element
      logic out_free;   // output register can take a word this cycle
   } dp_stat_type;

endpackage
`default_nettype wire

@@ src/bdq_ctrl.sv @@
// Controller state machine of the bounded deque with search.
`default_nettype none
module bdq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire bdq_pkg::dp_stat_type  stat,
   output bdq_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_READ = 4'b0100,
      S_USE  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = stat.scan_start ? S_READ : S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_USE;
         end
         S_USE: begin
            if (!stat.is_list) begin
               cmd.use_search = 1'b1;
               // The search result goes out through the single-result path.
               if (stat.idx_last) begin
                  state_in = S_EXEC;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_READ;
               end
            end else if (stat.out_free) begin
               cmd.emit_elem = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ src/bdq_dp.sv @@
// Datapath of the bounded deque: ring store, pointers, scan index and output register.
`default_nettype none
module bdq_dp #(
   parameter int CAPACITY = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [bdq_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic [bdq_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [bdq_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tlast,
   input  wire bdq_pkg::ctrl_cmd_type              cmd,
   output bdq_pkg::dp_stat_type                    stat
);

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam logic [SLOT_W:0]   CAP_S = (SLOT_W + 1)'(CAPACITY);
   localparam logic [FILL_W-1:0] CAP_F = FILL_W'(CAPACITY);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

   logic [bdq_pkg::ELEM_W-1:0] mem [CAPACITY];

   bdq_pkg::cmd_type           cmd_ff;
   logic [bdq_pkg::ELEM_W-1:0] val_ff;
   logic [SLOT_W-1:0]          head_ff, head_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [SLOT_W-1:0]          idx_ff;
   logic                       found_ff;
   logic [bdq_pkg::ELEM_W-1:0] rd_data_ff;

   logic                       rsp_valid_ff;
   logic [bdq_pkg::ELEM_W-1:0] rsp_elem_ff, rsp_elem_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [bdq_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   bdq_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic                       rsp_last_ff, rsp_last_in;

   bdq_pkg::cmd_type           req_cmd;
   logic                       full, empty, emit;
   logic                       mem_we;
   logic [SLOT_W-1:0]          mem_waddr;
   logic [SLOT_W:0]            rd_sum, back_sum;
   logic [SLOT_W-1:0]          rd_slot, back_slot, head_dec, head_inc;

   assign req_cmd = bdq_pkg::cmd_type'(req_tuser[bdq_pkg::CMD_W-1:0]);
   assign full    = (fill_ff == CAP_F);
   assign empty   = (fill_ff == '0);

   // Ring slot arithmetic: the head and scan index stay below the capacity and
   // the count never exceeds it, so one compare and subtract wraps the sum.
   assign rd_sum    = {1'b0, head_ff} + {1'b0, idx_ff};
   assign rd_slot   = (rd_sum >= CAP_S) ? SLOT_W'(rd_sum - CAP_S) : SLOT_W'(rd_sum);
   assign back_sum  = {1'b0, head_ff} + (SLOT_W + 1)'(fill_ff);
   assign back_slot = (back_sum >= CAP_S) ? SLOT_W'(back_sum - CAP_S) : SLOT_W'(back_sum);
   assign head_dec  = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign head_inc  = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;

   always_comb begin
      stat.scan_start = (req_cmd inside {bdq_pkg::CMD_SEARCH, bdq_pkg::CMD_LIST}) && !empty;
      stat.is_list    = (cmd_ff == bdq_pkg::CMD_LIST);
      stat.idx_last   = ((FILL_W'(idx_ff) + FILL_W'(1)) == fill_ff);
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      head_in       = head_ff;
      fill_in       = fill_ff;
      mem_we        = 1'b0;
      mem_waddr     = back_slot;
      rsp_status_in = bdq_pkg::ST_OK;
      rsp_found_in  = 1'b0;
      rsp_elem_in   = '0;
      rsp_last_in   = 1'b1;
      emit          = 1'b0;
      if (cmd.exec) begin
         emit = 1'b1;
         case (cmd_ff)
            bdq_pkg::CMD_PUSH_BACK: begin
               if (full) begin
                  rsp_status_in = bdq_pkg::ST_FULL;
               end else begin
                  mem_we  = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
            bdq_pkg::CMD_PUSH_FRONT: begin
               if (full) begin
                  rsp_status_in = bdq_pkg::ST_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = head_dec;
                  head_in   = head_dec;
                  fill_in   = fill_ff + 1'b1;
               end
            end
            bdq_pkg::CMD_POP_FRONT: begin
               if (empty) begin
                  rsp_status_in = bdq_pkg::ST_EMPTY;
               end else begin
                  head_in = head_inc;
                  fill_in = fill_ff - 1'b1;
               end
            end
            bdq_pkg::CMD_POP_BACK: begin
               if (empty) begin
                  rsp_status_in = bdq_pkg::ST_EMPTY;
               end else begin
                  fill_in = fill_ff - 1'b1;
               end
            end
            bdq_pkg::CMD_SEARCH: begin
               rsp_found_in = found_ff;
            end
            bdq_pkg::CMD_LIST: begin
               // Only an empty store reaches here for a listing.
               rsp_status_in = bdq_pkg::ST_EMPTY;
            end
            bdq_pkg::CMD_CLEAR: begin
               head_in = '0;
               fill_in = '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.emit_elem) begin
         emit        = 1'b1;
         rsp_elem_in = rd_data_ff;
         rsp_last_in = stat.idx_last;
      end
      rsp_count_in = bdq_pkg::COUNT_W'(fill_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff   <= req_cmd;
         val_ff   <= req_tdata[bdq_pkg::ELEM_W-1:0];
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.use_search && (rd_data_ff == val_ff)) begin
            found_ff <= 1'b1;
         end
      end
      if (emit) begin
         rsp_elem_ff   <= rsp_elem_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= val_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_slot];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_status_ff, rsp_count_ff, rsp_found_ff, rsp_elem_ff};

endmodule
`default_nettype wire

@@ src/bounded_deque_with_search_unit.sv @@
// Bounded double-ended queue of signed 32-bit values with search and listing.
// Usage: each request word carries a command in req_tuser and a value in req_tdata.
// Commands push at the back or front, pop at the front or back, search for the
// value, report the length, list every element front to back, or clear.
// Every command returns one response word with tlast set, except a listing of a
// non-empty store, which returns one word per element with tlast on the last.
// A single-result command is taken in the idle state, executed once the output
// register is free, and its response is then held in that register; a new
// request is taken only in the idle state. A search reads and compares each
// element through the single read port; a listing reads and emits each in turn.
// The response sits in an output register; while the receiver stalls, the block
// holds the word and waits before producing the next one, but it still takes a
// new request word once it has finished the current one.
// Reset clears the head pointer, the element count (empty store) and the output
// valid flag; the store contents are not cleared and need no clearing pass.
`default_nettype none
module bounded_deque_with_search_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // value[31:0]
   input  wire logic [bdq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command[2:0], zero above
   input  wire logic [bdq_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // element[31:0], found[32], count[37:33], status[39:38]
   output logic [bdq_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast
);

   bdq_pkg::ctrl_cmd_type ctrl_cmd;
   bdq_pkg::dp_stat_type  dp_stat;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (ctrl_cmd)
   );

   bdq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (ctrl_cmd),
      .stat       (dp_stat)
   );

endmodule
`default_nettype wire

@@ verif/bounded_deque_with_search_unit_tb.sv @@
// Self-checking testbench for the bounded deque with search: directed and random command words.
module bounded_deque_with_search_unit_tb;

   localparam int CAPACITY    = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 60;

   typedef struct {
      logic [bdq_pkg::ELEM_W-1:0]  element;
      logic                        found;
      logic [bdq_pkg::COUNT_W-1:0] count;
      bdq_pkg::status_type         status;
      logic                        last;
   } deque_rsp_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bdq_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic [bdq_pkg::REQ_USER_W-1:0]   req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bdq_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tlast;

   // Shadow copy of the deque, updated as each request word is accepted.
   logic [bdq_pkg::ELEM_W-1:0] deque_mem [CAPACITY];
   logic [3:0]                 deque_head = '0;
   int                         deque_fill = 0;
   deque_rsp_type              expected_rsp_q[$];
   deque_rsp_type              want;

   int errors        = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   bounded_deque_with_search_unit #(.CAPACITY(CAPACITY)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bounded_deque_with_search_unit_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Applies one command to the shadow deque and queues the words it should produce.
   function automatic void deque_apply(bdq_pkg::cmd_type cmd,
                                       logic [bdq_pkg::ELEM_W-1:0] val);
      deque_rsp_type r;
      logic [3:0]    slot;
      r = '{element: '0, found: 1'b0, count: '0, status: bdq_pkg::ST_OK, last: 1'b1};
      case (cmd)
         bdq_pkg::CMD_PUSH_BACK, bdq_pkg::CMD_PUSH_FRONT: begin
            if (deque_fill == CAPACITY) begin
               r.status = bdq_pkg::ST_FULL;
            end else if (cmd == bdq_pkg::CMD_PUSH_BACK) begin
               slot = deque_head + deque_fill[3:0];
               deque_mem[slot] = val;
               deque_fill++;
            end else begin
               deque_head = deque_head - 4'd1;
               deque_mem[deque_head] = val;
               deque_fill++;
            end
         end
         bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
            if (deque_fill == 0) begin
               r.status = bdq_pkg::ST_EMPTY;
            end else begin
               if (cmd == bdq_pkg::CMD_POP_FRONT) deque_head = deque_head + 4'd1;
               deque_fill--;
            end
         end
         bdq_pkg::CMD_SEARCH: begin
            for (int i = 0; i < deque_fill; i++) begin
               slot = deque_head + i[3:0];
               if (deque_mem[slot] == val) r.found = 1'b1;
            end
         end
         bdq_pkg::CMD_LIST: begin
            if (deque_fill == 0) begin
               r.status = bdq_pkg::ST_EMPTY;
            end else begin
               // A listing yields one word per element, front first.
               for (int i = 0; i < deque_fill; i++) begin
                  slot = deque_head + i[3:0];
                  r.element = deque_mem[slot];
                  r.count = deque_fill[bdq_pkg::COUNT_W-1:0];
                  r.last = (i == deque_fill - 1);
                  expected_rsp_q.push_back(r);
               end
               return;
            end
         end
         bdq_pkg::CMD_CLEAR: begin
            deque_head = '0;
            deque_fill = 0;
         end
         default: begin
         end
      endcase
      r.count = deque_fill[bdq_pkg::COUNT_W-1:0];
      expected_rsp_q.push_back(r);
   endfunction

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("element", want.element, rsp_tdata[31:0]);
            check_field("found", 32'(want.found), 32'(rsp_tdata[32]));
            check_field("count", 32'(want.count), 32'(rsp_tdata[37:33]));
            check_field("status", 32'(want.status), 32'(rsp_tdata[39:38]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   // Offers one request word and returns at the edge where it is taken; valid stays up.
   task automatic send_word(bdq_pkg::cmd_type cmd, logic [bdq_pkg::ELEM_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= $urandom;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= val;
      req_tuser <= {{(bdq_pkg::REQ_USER_W-bdq_pkg::CMD_W){1'b0}}, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      deque_apply(cmd, val);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_store();
      send_word(bdq_pkg::CMD_POP_FRONT, 32'h0);
      send_word(bdq_pkg::CMD_POP_BACK, 32'h0);
      send_word(bdq_pkg::CMD_LIST, 32'h0);
      send_word(bdq_pkg::CMD_SEARCH, 32'h0);
      send_word(bdq_pkg::CMD_LENGTH, 32'hFFFF_FFFF);
      send_word(bdq_pkg::CMD_CLEAR, 32'h0);
   endtask

   // Fills the store from both ends so the head wraps, then probes the full cases.
   task automatic test_full_store();
      logic [bdq_pkg::ELEM_W-1:0] val;
      for (int i = 0; i < CAPACITY; i++) begin
         case (i)
            0: val = 32'h7FFF_FFFF;
            1: val = 32'h8000_0000;
            2: val = 32'h0000_0000;
            3: val = 32'hFFFF_FFFF;
            default: val = i * 32'h0101_0101;
         endcase
         send_word((i % 2) ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK, val);
      end
      send_word(bdq_pkg::CMD_PUSH_BACK, 32'h5555_5555);
      send_word(bdq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
      send_word(bdq_pkg::CMD_SEARCH, 32'h8000_0000);
      send_word(bdq_pkg::CMD_SEARCH, 32'h1234_5678);
      send_word(bdq_pkg::CMD_LIST, 32'h0);
      send_word(bdq_pkg::CMD_POP_FRONT, 32'h0);
      send_word(bdq_pkg::CMD_POP_BACK, 32'h0);
      send_word(bdq_pkg::CMD_LENGTH, 32'h0);
      send_word(bdq_pkg::CMD_CLEAR, 32'h0);
   endtask

   // Random commands that drift between an empty and a full store.
   task automatic test_random_mix(int n);
      bdq_pkg::cmd_type           cmd;
      logic [bdq_pkg::ELEM_W-1:0] val;
      logic [3:0]                 pos;
      logic                       filling;
      logic                       front;
      int                         pick;
      filling = 1'b1;
      for (int k = 0; k < n; k++) begin
         if (deque_fill == CAPACITY) filling = 1'b0;
         else if (deque_fill == 0) filling = 1'b1;
         else if ($urandom_range(39) == 0) filling = !filling;
         pick = $urandom_range(99);
         front = 1'($urandom_range(1));
         if (pick < 2) cmd = bdq_pkg::CMD_CLEAR;
         else if (pick < 10) cmd = bdq_pkg::CMD_LIST;
         else if (pick < 14) cmd = bdq_pkg::CMD_LENGTH;
         else if (pick < 28) cmd = bdq_pkg::CMD_SEARCH;
         else if ((pick < 84) == filling)
            cmd = front ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK;
         else
            cmd = front ? bdq_pkg::CMD_POP_FRONT : bdq_pkg::CMD_POP_BACK;
         case ($urandom_range(5))
            0: val = 32'h7FFF_FFFF;
            1: val = 32'h8000_0000;
            2: val = $urandom_range(7);
            3: val = 32'hFFFF_FFFF - $urandom_range(3);
            default: val = $urandom;
         endcase
         if (cmd == bdq_pkg::CMD_SEARCH && deque_fill > 0 && $urandom_range(1)) begin
            pos = 4'($urandom_range(deque_fill - 1));
            val = deque_mem[deque_head + pos];
         end
         send_word(cmd, val);
         if (k == n / 2) wait_drained();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      rsp_stall_pct = 75;
      test_empty_store();
      test_full_store();
      test_random_mix(130);
      wait_drained();

      send_idle_pct = 75;
      rsp_stall_pct = 20;
      test_random_mix(130);
      wait_drained();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_mix(130);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("bounded_deque_with_search_unit_tb: PASS");
      end else begin
         $display("bounded_deque_with_search_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
